@@ hdl/fprx_pkg.sv @@
// ----------------------------------------------------------------------------
// fprx_pkg
// Shared types and codes for the framed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package fprx_pkg;

    // Largest accepted payload length.
    localparam int unsigned MAX_PAYLOAD = 513;

    localparam int unsigned LEN_W  = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned ID_W   = 16;
    localparam int unsigned IDX_W  = 2;

    // Parser states
    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_START2 = 3'd1,
        ST_CTRL   = 3'd2,
        ST_LEN_LO = 3'd3,
        ST_LEN_HI = 3'd4,
        ST_DATA   = 3'd5,
        ST_END1   = 3'd6,
        ST_END2   = 3'd7
    } parse_state_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_ABORT  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_START2  = 3'd1;
    localparam logic [2:0] ERR_CONTROL = 3'd2;
    localparam logic [2:0] ERR_LENGTH  = 3'd3;
    localparam logic [2:0] ERR_END1    = 3'd4;
    localparam logic [2:0] ERR_END2    = 3'd5;
    localparam logic [2:0] ERR_TIMEOUT = 3'd6;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_ID   = 2'd0;
    localparam logic [IDX_W-1:0] REG_CODE_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DMX_CODE   = 2'd2;

    // Input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [CNT_W-1:0]  control_code_count;
        logic [BYTE_W-1:0] dmx_data_code;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [LEN_W-1:0]  payload_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] control_code;
        logic              is_dmx;
        logic [LEN_W-1:0]  frame_length;
        logic [2:0]        error_code;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/framed_packet_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// framed_packet_receiver_unit
// Length-prefixed frame deframer with streaming payload output.
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled: a received byte (tuser = 0) or a
// read timeout (tuser = 1). Frames are start-lo, start-hi, control,
// length-lo, length-hi, payload, end-lo, end-hi; start bytes come from
// frame_id, end bytes are their inverse. Lengths above MAX_LEN (default 513)
// abort the frame. Each payload byte leaves at once with its index, and the
// frame closes with a commit or abort word; on abort the consumer must drop
// the payload it already took. Throughput is one word per cycle unless the
// output stalls: the parser updates on each accepted word and a one-deep
// output register holds the result, so m_axis_tvalid rises in the cycle after
// accept. s_axis_tready drops only while the output register is full and
// stalled. Config writes are accepted every cycle and should land while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_unit
    import fprx_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_PAYLOAD
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // config write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [ID_W-1:0]   cfg_data,
    // input words
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    input  wire logic              s_axis_tuser,   // [0] action
    // result words
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [39:0]            m_axis_tdata,   // [9:0] payload_index,
                                                   // [17:10] payload_byte,
                                                   // [25:18] control_code,
                                                   // [26] is_dmx,
                                                   // [36:27] frame_length,
                                                   // [39:37] error_code
    output logic [1:0]             m_axis_tuser    // [1:0] kind
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    // Config registers; unused index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_id           <= '0;
            cfg_reg.control_code_count <= CNT_W'(256);
            cfg_reg.dmx_data_code      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_ID:   cfg_reg.frame_id           <= cfg_data;
                REG_CODE_COUNT: cfg_reg.control_code_count <= cfg_data[CNT_W-1:0];
                REG_DMX_CODE:   cfg_reg.dmx_data_code      <= cfg_data[BYTE_W-1:0];
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    fprx_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .action  (s_axis_tuser),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register: valid flag reset, payload loaded on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= step && result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {out_reg.error_code, out_reg.frame_length, out_reg.is_dmx,
                            out_reg.control_code, out_reg.payload_byte,
                            out_reg.payload_index};

endmodule

`default_nettype wire

@@ hdl/fprx_parser.sv @@
// ----------------------------------------------------------------------------
// fprx_parser
// Frame state machine: holds frame context, updates it on each accepted word
// and forms the result word for that step.
// ----------------------------------------------------------------------------
`default_nettype none

module fprx_parser
    import fprx_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_PAYLOAD
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              action,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    output result_t                result
);

    parse_state_t      state_reg, state_next;
    logic [BYTE_W-1:0] ctrl_reg, ctrl_next;
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    logic              timeout;
    logic [BYTE_W-1:0] start_lo, start_hi;
    logic [15:0]       len_word;
    logic              len_bad;
    logic              ctrl_bad;
    logic              ctrl_known;
    logic [LEN_W-1:0]  count_inc;

    assign timeout    = (action == ACT_TIMEOUT);
    assign start_lo   = cfg.frame_id[7:0];
    assign start_hi   = cfg.frame_id[15:8];
    assign len_word   = {rx_byte, len_lo_reg};
    assign len_bad    = (len_word > 16'(MAX_LEN));
    assign ctrl_bad   = ({1'b0, rx_byte} >= cfg.control_code_count);
    assign ctrl_known = (state_reg >= ST_LEN_LO);
    assign count_inc  = count_reg + LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            ctrl_reg    <= '0;
            len_lo_reg  <= '0;
            exp_len_reg <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            ctrl_reg    <= ctrl_next;
            len_lo_reg  <= len_lo_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
        end
    end

    // Next state and context
    always_comb
    begin
        state_next   = state_reg;
        ctrl_next    = ctrl_reg;
        len_lo_next  = len_lo_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        if (state_reg == ST_HUNT)
        begin
            if (!timeout && rx_byte == start_lo)
            begin
                state_next = ST_START2;
                count_next = '0;
            end
        end
        else if (timeout)
        begin
            state_next = ST_HUNT;
        end
        else
        begin
            unique case (state_reg)
                ST_START2: state_next = (rx_byte == start_hi) ? ST_CTRL : ST_HUNT;
                ST_CTRL:
                begin
                    if (ctrl_bad)
                        state_next = ST_HUNT;
                    else
                    begin
                        ctrl_next  = rx_byte;
                        state_next = ST_LEN_LO;
                    end
                end
                ST_LEN_LO:
                begin
                    len_lo_next = rx_byte;
                    state_next  = ST_LEN_HI;
                end
                ST_LEN_HI:
                begin
                    if (len_bad)
                        state_next = ST_HUNT;
                    else
                    begin
                        exp_len_next = len_word[LEN_W-1:0];
                        count_next   = '0;
                        state_next   = (len_word[LEN_W-1:0] == '0) ? ST_END1 : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    count_next = count_inc;
                    if (count_inc >= exp_len_reg)
                        state_next = ST_END1;
                end
                ST_END1: state_next = (rx_byte == ~start_lo) ? ST_END2 : ST_HUNT;
                ST_END2: state_next = ST_HUNT;
                default: state_next = ST_HUNT;
            endcase
        end
    end

    // Result word for this step
    always_comb
    begin
        result               = '0;
        result.payload_index = count_reg;
        result.control_code  = ctrl_known ? ctrl_reg : '0;
        if (state_reg != ST_HUNT)
        begin
            if (timeout)
            begin
                result.valid      = 1'b1;
                result.kind       = KIND_ABORT;
                result.error_code = ERR_TIMEOUT;
            end
            else
            begin
                unique case (state_reg)
                    ST_START2:
                    begin
                        result.valid      = (rx_byte != start_hi);
                        result.kind       = KIND_ABORT;
                        result.error_code = ERR_START2;
                    end
                    ST_CTRL:
                    begin
                        // rejected byte is reported as the control code
                        result.valid        = ctrl_bad;
                        result.kind         = KIND_ABORT;
                        result.error_code   = ERR_CONTROL;
                        result.control_code = rx_byte;
                    end
                    ST_LEN_HI:
                    begin
                        result.valid      = len_bad;
                        result.kind       = KIND_ABORT;
                        result.error_code = ERR_LENGTH;
                    end
                    ST_DATA:
                    begin
                        result.valid        = 1'b1;
                        result.kind         = KIND_DATA;
                        result.payload_byte = rx_byte;
                    end
                    ST_END1:
                    begin
                        result.valid      = (rx_byte != ~start_lo);
                        result.kind       = KIND_ABORT;
                        result.error_code = ERR_END1;
                    end
                    ST_END2:
                    begin
                        result.valid = 1'b1;
                        if (rx_byte != ~start_hi)
                        begin
                            result.kind       = KIND_ABORT;
                            result.error_code = ERR_END2;
                        end
                        else
                        begin
                            result.kind         = KIND_COMMIT;
                            result.frame_length = exp_len_reg;
                        end
                    end
                    default: result.valid = 1'b0;
                endcase
            end
        end
        // control is known once accepted, and for the rejected control byte
        result.is_dmx = (ctrl_known || (state_reg == ST_CTRL && !timeout)) &&
                        (result.control_code == cfg.dmx_data_code);
    end

endmodule

`default_nettype wire

@@ hdl/fprx_checker.sv @@
// ----------------------------------------------------------------------------
// fprx_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module fprx_checker
    import fprx_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // data words carry no error and no length
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DATA |->
            m_axis_tdata[39:37] == ERR_NONE && m_axis_tdata[36:27] == '0)
        else $error("data word with error or length");

    // aborts always carry a reason
    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ABORT |-> m_axis_tdata[39:37] != ERR_NONE)
        else $error("abort without error code");

    // commit: streamed count matches declared length
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_COMMIT |->
            m_axis_tdata[9:0] == m_axis_tdata[36:27] && m_axis_tdata[39:37] == ERR_NONE)
        else $error("commit count mismatch");

endmodule

bind framed_packet_receiver_unit fprx_checker u_fprx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for framed_packet_receiver_unit.
// ----------------------------------------------------------------------------
// Streams received bytes and read timeouts into the deframer and predicts
// every payload, commit and abort word from its own copy of the parser.
// Well-formed frames with random content dominate, mixed with broken frames
// (bad start, control, length and end bytes, timeouts) and line noise. The
// register set is changed between phases while the block is idle; random
// gaps on the input and stalls on the output move across the run.
// ----------------------------------------------------------------------------

module tb_top;

    import fprx_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;   // cycles with no handshake at all
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // one word on the input side: action + byte
    typedef struct packed {
        logic       act;
        logic [7:0] b;
    } rx_word_t;

    // ways a generated frame can be spoiled
    typedef enum int {
        FLAW_NONE,
        FLAW_START2,
        FLAW_CONTROL,
        FLAW_LENGTH,
        FLAW_END1,
        FLAW_END2,
        FLAW_TIMEOUT
    } flaw_t;

    // ------------------------------------------------------------------------
    // Frame tracker: shadow parser plus the queue of reports it expects.
    // ------------------------------------------------------------------------
    class frame_tracker;

        // same layout as {m_axis_tuser, m_axis_tdata}
        typedef struct packed {
            logic [1:0]        kind;
            logic [2:0]        error_code;
            logic [LEN_W-1:0]  frame_length;
            logic              is_dmx;
            logic [BYTE_W-1:0] control_code;
            logic [BYTE_W-1:0] payload_byte;
            logic [LEN_W-1:0]  payload_index;
        } frame_report_t;

        logic [ID_W-1:0]   frame_id;
        logic [CNT_W-1:0]  code_limit;
        logic [BYTE_W-1:0] dmx_code;

        parse_state_t      state;
        logic [7:0]        held_ctrl;
        logic [7:0]        len_lo;
        logic [LEN_W-1:0]  exp_len;
        logic [LEN_W-1:0]  rx_count;

        frame_report_t     due_reports[$];
        int                errors;

        function new();
            frame_id   = '0;
            code_limit = 9'd256;
            dmx_code   = '0;
            state      = ST_HUNT;
            held_ctrl  = '0;
            len_lo     = '0;
            exp_len    = '0;
            rx_count   = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [ID_W-1:0] val);
            case (idx)
                REG_FRAME_ID:   frame_id   = val;
                REG_CODE_COUNT: code_limit = val[CNT_W-1:0];
                REG_DMX_CODE:   dmx_code   = val[BYTE_W-1:0];
                default: ;      // unused index: dropped
            endcase
        endfunction

        function void post(logic [1:0] kind, logic [LEN_W-1:0] idx, logic [7:0] data,
                           logic [7:0] ctrl, logic ctrl_known, logic [LEN_W-1:0] flen,
                           logic [2:0] err);
            frame_report_t r;
            r.kind          = kind;
            r.error_code    = err;
            r.frame_length  = flen;
            r.control_code  = ctrl_known ? ctrl : 8'h00;
            r.is_dmx        = ctrl_known && (ctrl == dmx_code);
            r.payload_byte  = data;
            r.payload_index = idx;
            due_reports.push_back(r);
        endfunction

        function void abandon(logic [2:0] err, logic [7:0] ctrl, logic ctrl_known);
            post(KIND_ABORT, rx_count, 8'h00, ctrl, ctrl_known, '0, err);
            state = ST_HUNT;
        endfunction

        // one accepted input word
        function void take_rx_word(logic act, logic [7:0] b);
            logic [15:0] len;
            logic        ctrl_known;
            ctrl_known = (state >= ST_LEN_LO);
            if (state == ST_HUNT) begin
                if (act == ACT_BYTE && b == frame_id[7:0]) begin
                    state    = ST_START2;
                    rx_count = '0;
                end
                return;
            end
            if (act == ACT_TIMEOUT) begin
                abandon(ERR_TIMEOUT, held_ctrl, ctrl_known);
                return;
            end
            case (state)
                ST_START2:
                    if (b != frame_id[15:8])
                        abandon(ERR_START2, 8'h00, 1'b0);
                    else
                        state = ST_CTRL;
                ST_CTRL:
                    if ({1'b0, b} >= code_limit)
                        abandon(ERR_CONTROL, b, 1'b1);
                    else
                    begin
                        held_ctrl = b;
                        state     = ST_LEN_LO;
                    end
                ST_LEN_LO:
                begin
                    len_lo = b;
                    state  = ST_LEN_HI;
                end
                ST_LEN_HI:
                begin
                    len = {b, len_lo};
                    if (len > MAX_PAYLOAD)
                        abandon(ERR_LENGTH, held_ctrl, 1'b1);
                    else
                    begin
                        exp_len  = len[LEN_W-1:0];
                        rx_count = '0;
                        state    = (exp_len == 0) ? ST_END1 : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    post(KIND_DATA, rx_count, b, held_ctrl, 1'b1, '0, ERR_NONE);
                    rx_count = rx_count + 1'b1;
                    if (rx_count >= exp_len)
                        state = ST_END1;
                end
                ST_END1:
                    if (b != (frame_id[7:0] ^ 8'hFF))
                        abandon(ERR_END1, held_ctrl, 1'b1);
                    else
                        state = ST_END2;
                default:
                    if (b != (frame_id[15:8] ^ 8'hFF))
                        abandon(ERR_END2, held_ctrl, 1'b1);
                    else
                    begin
                        post(KIND_COMMIT, rx_count, 8'h00, held_ctrl, 1'b1, exp_len,
                             ERR_NONE);
                        state = ST_HUNT;
                    end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // one accepted result word
        function void check_report(logic [1:0] kind, logic [39:0] data);
            frame_report_t got;
            frame_report_t want;
            got = {kind, data};
            if (due_reports.size() == 0)
            begin
                $error("result word with nothing outstanding (kind %0d)", kind);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("kind",          16'(want.kind),          16'(got.kind));
            compare_field("payload_index", 16'(want.payload_index), 16'(got.payload_index));
            compare_field("payload_byte",  16'(want.payload_byte),  16'(got.payload_byte));
            compare_field("control_code",  16'(want.control_code),  16'(got.control_code));
            compare_field("is_dmx",        16'(want.is_dmx),        16'(got.is_dmx));
            compare_field("frame_length",  16'(want.frame_length),  16'(got.frame_length));
            compare_field("error_code",    16'(want.error_code),    16'(got.error_code));
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [ID_W-1:0]   cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] rx_byte
    logic              s_axis_tuser;    // [0] action
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [39:0]       m_axis_tdata;    // [9:0] index, [17:10] byte, [25:18] ctrl,
                                        // [26] is_dmx, [36:27] length, [39:37] error
    logic [1:0]        m_axis_tuser;    // [1:0] kind

    framed_packet_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    frame_tracker tracker;

    int unsigned n_sent;        // input words accepted so far
    int unsigned gap_pct;       // chance of an input gap burst per word
    int unsigned stall_pct;     // chance of an output stall burst per cycle
    int unsigned stuck_cycles;

    // what the register set holds now, for building frames
    logic [15:0] cur_id;
    int unsigned cur_count;
    logic [7:0]  cur_dmx;

    // ------------------------------------------------------------------------
    // Monitor + watchdog. Sampled at the rising edge, before any NBA update.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_rx_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_report(m_axis_tuser, m_axis_tdata);

            if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: random stall bursts, none when stall_pct is 0.
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All called at a falling edge and return at a falling edge.
    // ------------------------------------------------------------------------

    // push one word; valid stays high on return so back-to-back words stream
    task automatic send_word(input logic act, input logic [7:0] b);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        n_sent++;
    endtask

    // build one frame for the current register set, spoil it as asked, send it
    task automatic send_frame(input logic [7:0] ctrl, input int unsigned len,
                              input flaw_t flaw);
        rx_word_t    words[$];
        logic [15:0] wlen;
        logic [7:0]  end_lo;
        logic [7:0]  end_hi;
        int unsigned pos;
        int unsigned i;
        wlen = 16'(len);
        if (flaw == FLAW_LENGTH)
            wlen = $urandom_range(0, 1) ? 16'(MAX_PAYLOAD + 1)
                                        : 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
        end_lo = cur_id[7:0] ^ 8'hFF;
        end_hi = cur_id[15:8] ^ 8'hFF;
        if (flaw == FLAW_END1)
            end_lo = end_lo ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_END2)
            end_hi = end_hi ^ 8'($urandom_range(1, 255));

        words.push_back({ACT_BYTE, cur_id[7:0]});
        if (flaw == FLAW_START2)
            words.push_back({ACT_BYTE, cur_id[15:8] ^ 8'($urandom_range(1, 255))});
        else
            words.push_back({ACT_BYTE, cur_id[15:8]});
        words.push_back({ACT_BYTE, ctrl});
        words.push_back({ACT_BYTE, wlen[7:0]});
        words.push_back({ACT_BYTE, wlen[15:8]});
        for (i = 0; i < len; i++)
            words.push_back({ACT_BYTE, 8'($urandom)});
        words.push_back({ACT_BYTE, end_lo});
        words.push_back({ACT_BYTE, end_hi});

        // drop what follows an early abort; it would only be hunt noise
        case (flaw)
            FLAW_START2:  words = words[0:1];
            FLAW_CONTROL: words = words[0:2];
            FLAW_LENGTH:  words = words[0:4];
            FLAW_TIMEOUT:
            begin
                // timeout replaces any word after the first start byte
                pos   = $urandom_range(1, words.size() - 1);
                words = words[0:pos-1];
                words.push_back({ACT_TIMEOUT, 8'($urandom)});
            end
            default: ;
        endcase

        foreach (words[k])
            send_word(words[k].act, words[k].b);
    endtask

    // wait for the block to go quiet, then write the register set
    task automatic program_regs(input logic [15:0] id, input logic [8:0] count,
                                input logic [7:0] dmx, input bit poke_unused);
        logic [IDX_W-1:0] idx[4];
        logic [ID_W-1:0]  val[4];
        int unsigned      n;
        idx = '{REG_FRAME_ID, REG_CODE_COUNT, REG_DMX_CODE, REG_UNUSED};
        val = '{id, {7'd0, count}, {8'd0, dmx}, 16'($urandom)};
        n   = poke_unused ? 4 : 3;

        s_axis_tvalid <= 1'b0;
        while (tracker.due_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);  // last word may still be in the output reg

        // unused index goes last so a stray write would show up
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cur_id    = id;
        cur_count = 32'(count);
        cur_dmx   = dmx;
    endtask

    // random mix: mostly good frames, some broken ones, some line noise
    task automatic run_traffic(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        int unsigned ok_top;
        int unsigned r;
        logic [7:0]  ctrl;
        flaw_t       flaw;
        stop_at = n_sent + n_words;
        while (n_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(($urandom_range(0, 7) == 0) ? ACT_TIMEOUT : ACT_BYTE,
                              ($urandom_range(0, 3) == 0) ? cur_id[7:0] : 8'($urandom));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    len = $urandom_range(0, 6);
                else if (r < 97)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(41, 200);

                ok_top = (cur_count >= 256) ? 255 : cur_count - 1;
                ctrl   = (cur_count == 0) ? 8'($urandom) : 8'($urandom_range(0, ok_top));
                if ($urandom_range(0, 3) == 0)
                    ctrl = cur_dmx;

                flaw = (pick < 75) ? FLAW_NONE
                                   : flaw_t'($urandom_range(FLAW_START2, FLAW_TIMEOUT));
                if (flaw == FLAW_CONTROL)
                begin
                    if (cur_count > 255)
                        flaw = FLAW_NONE;
                    else
                        ctrl = 8'($urandom_range(cur_count, 255));
                end
                send_frame(ctrl, len, flaw);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tracker       = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_BYTE;
        n_sent        = 0;
        stuck_cycles  = 0;
        gap_pct       = 20;
        stall_pct     = 20;
        cur_id        = '0;
        cur_count     = 256;
        cur_dmx       = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset registers: start 00 00, end FF FF, all codes legal
        send_word(ACT_BYTE, 8'h5A);          // noise while hunting
        send_word(ACT_TIMEOUT, 8'hFF);       // timeout while hunting: ignored
        send_frame(8'h00, 0, FLAW_NONE);     // zero length, control matches DMX code
        send_frame(8'hFF, 2, FLAW_NONE);     // top control code, short payload
        send_frame(8'h00, 0, FLAW_START2);   // bad second start byte
        send_frame(8'h01, 1, FLAW_TIMEOUT);  // timeout somewhere inside a frame

        // all-ones id, all codes legal, DMX code at top; one maximum-size frame
        gap_pct   = 10;
        stall_pct = 10;
        program_regs(16'hFFFF, 9'd256, 8'hFF, 1'b0);
        send_frame(8'($urandom), MAX_PAYLOAD, FLAW_NONE);
        run_traffic(150);

        // only control code 0 legal; input gaps, no output stalls
        gap_pct   = 30;
        stall_pct = 0;
        program_regs(16'($urandom), 9'd1, 8'h00, 1'b1);
        run_traffic(150);

        // random limit and DMX code; heavy output backpressure
        gap_pct   = 0;
        stall_pct = 40;
        program_regs(16'($urandom), 9'($urandom_range(2, 255)), 8'($urandom), 1'b1);
        run_traffic(150);

        // every control code rejected
        gap_pct   = 15;
        stall_pct = 15;
        program_regs(16'($urandom), 9'd0, 8'($urandom), 1'b0);
        run_traffic(60);

        // top of the count field; full speed on both sides to the end
        gap_pct   = 0;
        stall_pct = 0;
        program_regs(16'($urandom), 9'd511, 8'($urandom), 1'b1);
        run_traffic(150);

        // drain
        s_axis_tvalid <= 1'b0;
        while (tracker.due_reports.size() != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        if (tracker.errors == 0 && tracker.due_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
